@@ design/hwdf_pkg.sv @@
// Package with shared constants and types of the hash window duplicate filter.
`timescale 1ns / 1ps

package hwdf_pkg;

    localparam int unsigned TABLE_DEPTH = 65536;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned HASH_W      = 32;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned TAG_W       = 16;
    localparam int unsigned WIN_W       = 16;
    localparam int unsigned ENTRY_W     = TAG_W + TIME_W;
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(30);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ design/hwdf_if.sv @@
// Channel interfaces for packets, results and the window register write.
`timescale 1ns / 1ps

interface hwdf_in_if;
    logic                      valid;
    logic                      ready;
    logic [hwdf_pkg::HASH_W-1:0] packet_hash;
    logic [hwdf_pkg::TIME_W-1:0] packet_time;
    logic                      allow_duplicate;

    modport source (output valid, output packet_hash, output packet_time,
                    output allow_duplicate, input ready);
    modport sink (input valid, input packet_hash, input packet_time,
                  input allow_duplicate, output ready);
endinterface

interface hwdf_out_if;
    logic valid;
    logic ready;
    logic is_duplicate;

    modport source (output valid, output is_duplicate, input ready);
    modport sink (input valid, input is_duplicate, output ready);
endinterface

interface hwdf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [hwdf_pkg::WIN_W-1:0] window_seconds;

    modport source (output valid, output window_seconds, input ready);
    modport sink (input valid, input window_seconds, output ready);
endinterface

@@ design/hwdf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module hwdf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/hwdf_ctrl.sv @@
// Controller state machine for the clearing sweep, table lookup and update.
`timescale 1ns / 1ps

module hwdf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pkt_valid,
    input  hwdf_pkg::t_dp_status i_status,
    output logic                 o_pkt_ready,
    output hwdf_pkg::t_dp_cmd    o_cmd
);
    import hwdf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pkt_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_pkt_ready = 1'b1;
                if (i_pkt_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ design/hwdf_datapath.sv @@
// Datapath with the slot table, window register, comparison and result register.
`timescale 1ns / 1ps

module hwdf_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hwdf_pkg::t_dp_cmd            i_cmd,
    output hwdf_pkg::t_dp_status         o_status,
    input  logic [hwdf_pkg::HASH_W-1:0]  i_packet_hash,
    input  logic [hwdf_pkg::TIME_W-1:0]  i_packet_time,
    input  logic                         i_allow_duplicate,
    input  logic                         i_cfg_valid,
    input  logic [hwdf_pkg::WIN_W-1:0]   i_window_seconds,
    input  logic                         i_res_ready,
    output logic                         o_res_valid,
    output logic                         o_is_duplicate
);
    import hwdf_pkg::*;

    logic [IDX_W-1:0]   r_clr_addr;
    logic [WIN_W-1:0]   r_window;
    logic [IDX_W-1:0]   r_idx;
    logic [TAG_W-1:0]   r_tag;
    logic [TIME_W-1:0]  r_time;
    logic               r_allow;
    logic               r_out_valid;
    logic               r_is_dup;
    logic [ENTRY_W-1:0] rd_entry;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [TAG_W-1:0]   old_tag;
    logic [TIME_W-1:0]  old_time;
    logic [TIME_W:0]    diff;
    logic               in_window;
    logic               dup;

    hwdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (i_packet_hash[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    assign old_tag   = rd_entry[ENTRY_W-1:TIME_W];
    assign old_time  = rd_entry[TIME_W-1:0];
    assign diff      = {1'b0, r_time} - {1'b0, old_time};
    assign in_window = $signed(diff) <= $signed({{(TIME_W + 1 - WIN_W){1'b0}}, r_window});
    assign dup       = !r_allow && in_window && (old_tag == r_tag);

    assign ram_we    = i_cmd.clear_wr || (i_cmd.commit && !r_allow);
    assign ram_waddr = i_cmd.clear_wr ? r_clr_addr : r_idx;
    assign ram_wdata = i_cmd.clear_wr ? '0 : {r_tag, r_time};

    assign o_status.clear_last = (r_clr_addr == IDX_W'(TABLE_DEPTH - 1));
    assign o_status.out_free   = !r_out_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_window    <= WIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_valid) begin
                r_window <= i_window_seconds;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx   <= i_packet_hash[IDX_W-1:0];
            r_tag   <= i_packet_hash[HASH_W-1:HASH_W-TAG_W];
            r_time  <= i_packet_time;
            r_allow <= i_allow_duplicate;
        end
        if (i_cmd.commit) begin
            r_is_dup <= dup;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_is_duplicate = r_is_dup;

endmodule

@@ design/hash_window_duplicate_filter.sv @@
// Hash window duplicate filter: a direct-mapped slot table flags repeated packets.
// The result enters the output register once the table has been read and the output register is free.
// A new packet is not taken until the previous one has been committed with its table write-back.
// After reset the table is cleared by a sweep over all 65536 slots; no packet is taken then.
// The window register resets to 30 and can be written during the sweep.
`timescale 1ns / 1ps

module hash_window_duplicate_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hwdf_in_if.sink     i_pkt,
    hwdf_out_if.source  o_res,
    hwdf_cfg_if.sink    i_cfg
);
    import hwdf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign i_cfg.ready = 1'b1;

    hwdf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (i_pkt.valid),
        .i_status    (status),
        .o_pkt_ready (i_pkt.ready),
        .o_cmd       (cmd)
    );

    hwdf_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_packet_hash     (i_pkt.packet_hash),
        .i_packet_time     (i_pkt.packet_time),
        .i_allow_duplicate (i_pkt.allow_duplicate),
        .i_cfg_valid       (i_cfg.valid),
        .i_window_seconds  (i_cfg.window_seconds),
        .i_res_ready       (o_res.ready),
        .o_res_valid       (o_res.valid),
        .o_is_duplicate    (o_res.is_duplicate)
    );

endmodule

@@ design/hwdf_checker.sv @@
// Port-level checker of the hash window duplicate filter and its bind statement.
`timescale 1ns / 1ps

module hwdf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");

    a_sweep_blocks_input: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("Packet channel ready at the start of the clearing sweep.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("Packet channel ready while a transaction is being looked up.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("Result dropped before its transaction completed.");

endmodule

bind hash_window_duplicate_filter hwdf_checker u_hwdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pkt.valid),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);

@@ dv/hash_window_duplicate_filter_tb.sv @@
// Self-checking testbench for the hash window duplicate filter with a slot table predictor.
`timescale 1ns / 1ps

module hash_window_duplicate_filter_tb;
    import hwdf_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int POOL_SLOTS = 16;
    localparam int POOL_TAGS = 4;
    localparam int PHASE_ITEMS = 472;

    typedef struct packed {
        logic [HASH_W-1:0] pkt_hash;
        logic [TIME_W-1:0] pkt_time;
        logic              allow_dup;
    } t_packet;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hwdf_in_if  pkt_if ();
    hwdf_out_if res_if ();
    hwdf_cfg_if cfg_if ();

    hash_window_duplicate_filter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    bit [TIME_W-1:0]  seen_time [TABLE_DEPTH];
    bit [TAG_W-1:0]   seen_tag [TABLE_DEPTH];
    bit [WIN_W-1:0]   window_model = WIN_RESET;
    bit               verdict_q [$];
    t_packet          pending_pkts [$];
    bit [TIME_W-1:0]  planned_time [bit [IDX_W-1:0]];
    bit [IDX_W-1:0]   pool_slot [POOL_SLOTS];
    bit [TAG_W-1:0]   pool_tag [POOL_TAGS];
    int unsigned      queued_count = 0;
    int unsigned      accepted_count = 0;
    int unsigned      mismatches = 0;
    int unsigned      src_idle_pct = 0;
    int unsigned      snk_stall_pct = 0;
    bit               pkt_slot_free = 1'b1;
    t_packet          next_pkt;

    always #CLK_HALF i_clk = ~i_clk;

    function automatic bit judge_packet(t_packet p);
        int unsigned     slot;
        bit [TAG_W-1:0]  tag;
        bit              hit;
        if (p.allow_dup) begin
            return 1'b0;
        end
        slot = p.pkt_hash % TABLE_DEPTH;
        tag = p.pkt_hash[HASH_W-1 -: TAG_W];
        hit = (tag == seen_tag[slot]) &&
              (p.pkt_time <= seen_time[slot] || p.pkt_time - seen_time[slot] <= window_model);
        seen_time[slot] = p.pkt_time;
        seen_tag[slot] = tag;
        return hit;
    endfunction

    function automatic void report_failure(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void queue_packet(logic [HASH_W-1:0] h, logic [TIME_W-1:0] t,
                                         logic allow);
        t_packet p;
        p.pkt_hash = h;
        p.pkt_time = t;
        p.allow_dup = allow;
        pending_pkts.push_back(p);
        queued_count++;
        if (!allow) begin
            planned_time[h[IDX_W-1:0]] = t;
        end
    endfunction

    function automatic void plan_random_packet(int unsigned win);
        int unsigned        kind;
        bit [IDX_W-1:0]     slot;
        bit [TIME_W-1:0]    base;
        int                 delta;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            slot = pool_slot[$urandom_range(0, POOL_SLOTS - 1)];
            base = planned_time.exists(slot) ? planned_time[slot] : '0;
            case ($urandom_range(0, 4))
                0: delta = $urandom_range(0, win);
                1: delta = win;
                2: delta = win + 1 + $urandom_range(0, 3);
                3: delta = -int'($urandom_range(1, 1000));
                default: delta = $urandom;
            endcase
            queue_packet({pool_tag[$urandom_range(0, POOL_TAGS - 1)], slot},
                         base + TIME_W'(delta), 1'b0);
        end else if (kind < 85) begin
            queue_packet(kind[0] ? $urandom : {pool_tag[$urandom_range(0, POOL_TAGS - 1)],
                         pool_slot[$urandom_range(0, POOL_SLOTS - 1)]}, $urandom, 1'b1);
        end else if (kind < 90) begin
            queue_packet({TAG_W'(0), IDX_W'($urandom)}, $urandom_range(0, win + 2), 1'b0);
        end else begin
            queue_packet($urandom, $urandom, 1'b0);
        end
    endfunction

    always @(negedge i_clk) begin
        res_if.ready = ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(negedge i_clk) begin
        if (pkt_slot_free) begin
            if (pending_pkts.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_pkt = pending_pkts.pop_front();
                pkt_if.packet_hash = next_pkt.pkt_hash;
                pkt_if.packet_time = next_pkt.pkt_time;
                pkt_if.allow_duplicate = next_pkt.allow_dup;
                pkt_if.valid = 1'b1;
                pkt_slot_free = 1'b0;
            end else begin
                pkt_if.valid = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_packet p;
        if (i_rst_n && pkt_if.valid && pkt_if.ready) begin
            p.pkt_hash = pkt_if.packet_hash;
            p.pkt_time = pkt_if.packet_time;
            p.allow_dup = pkt_if.allow_duplicate;
            verdict_q.push_back(judge_packet(p));
            accepted_count++;
            pkt_slot_free = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (verdict_q.size() == 0) begin
                report_failure($sformatf("result transaction with none expected, is_duplicate=%0b",
                                         res_if.is_duplicate));
            end else begin
                want = verdict_q.pop_front();
                if (res_if.is_duplicate !== want) begin
                    report_failure($sformatf("is_duplicate mismatch: expected %0b, actual %0b",
                                             want, res_if.is_duplicate));
                end
            end
        end
    end

    task automatic set_window(input logic [WIN_W-1:0] value);
        @(negedge i_clk);
        cfg_if.window_seconds = value;
        cfg_if.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        window_model = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (accepted_count != queued_count || verdict_q.size() != 0);
    endtask

    task automatic run_phase(int unsigned src_pct, int unsigned snk_pct,
                             logic [WIN_W-1:0] win);
        wait_drained();
        set_window(win);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            plan_random_packet(win);
        end
        wait_drained();
    endtask

    initial begin
        pkt_if.valid = 1'b0;
        pkt_if.packet_hash = '0;
        pkt_if.packet_time = '0;
        pkt_if.allow_duplicate = 1'b0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.window_seconds = '0;
        pool_slot[0] = '0;
        pool_slot[1] = '1;
        for (int i = 2; i < POOL_SLOTS; i++) begin
            pool_slot[i] = $urandom;
        end
        pool_tag[0] = '0;
        pool_tag[1] = '1;
        for (int i = 2; i < POOL_TAGS; i++) begin
            pool_tag[i] = $urandom;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The window still holds its reset value for these transactions.
        queue_packet(32'h0000_0005, 32'd10, 1'b0);
        queue_packet(32'h1234_0006, 32'd0, 1'b0);
        queue_packet(32'h1234_0006, 32'd30, 1'b0);
        queue_packet(32'h1234_0006, 32'd61, 1'b0);
        queue_packet(32'h1234_0006, 32'd5, 1'b0);
        queue_packet(32'hABCD_0006, 32'd40, 1'b1);
        queue_packet(32'h1234_0006, 32'd35, 1'b0);
        queue_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_packet(32'hFFFF_FFFF, 32'd0, 1'b0);
        queue_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_packet(32'h0000_0000, 32'd0, 1'b0);
        queue_packet(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        queue_packet(32'h0001_0000, 32'd1, 1'b0);
        queue_packet(32'h0001_0000, 32'd31, 1'b0);

        run_phase(0, 0, '0);
        run_phase(81, 0, '1);
        run_phase(0, 81, WIN_W'($urandom_range(1, 65534)));
        run_phase(36, 36, WIN_W'($urandom_range(0, 200)));

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ hash_window_duplicate_filter.f @@
design/hwdf_pkg.sv
design/hwdf_if.sv
design/hwdf_ram.sv
design/hwdf_ctrl.sv
design/hwdf_datapath.sv
design/hash_window_duplicate_filter.sv
design/hwdf_checker.sv
dv/hash_window_duplicate_filter_tb.sv
